/* rtl/core/lsp_pkg.sv */
package lsp_pkg;

   // Parser phase.
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_ENC     = 3'd1,
      PH_COLLECT = 3'd2,
      PH_SDATA   = 3'd3,
      PH_BACKLEN = 3'd4,
      PH_DONE    = 3'd5,
      PH_ERROR   = 3'd6
   } phase_type;

   // Encoding of the element whose payload bytes are being collected.
   typedef enum logic [3:0] {
      K_INT7  = 4'd0,
      K_STR6  = 4'd1,
      K_INT13 = 4'd2,
      K_INT16 = 4'd3,
      K_INT24 = 4'd4,
      K_INT32 = 4'd5,
      K_INT64 = 4'd6,
      K_STR12 = 4'd7,
      K_STR32 = 4'd8
   } enc_kind_type;

   // Kind of a result event.
   typedef enum logic [2:0] {
      EV_INT       = 3'd0,
      EV_STR_START = 3'd1,
      EV_STR_BYTE  = 3'd2,
      EV_DONE      = 3'd3,
      EV_ERROR     = 3'd4
   } event_kind_type;

   // Fixed encoding bytes of the multi-byte encodings.
   localparam logic [7:0] ENC_STR32 = 8'hF0;
   localparam logic [7:0] ENC_INT16 = 8'hF1;
   localparam logic [7:0] ENC_INT24 = 8'hF2;
   localparam logic [7:0] ENC_INT32 = 8'hF3;
   localparam logic [7:0] ENC_INT64 = 8'hF4;

   // Header byte positions of the element count.
   localparam logic [2:0] HDR_COUNT_LO = 3'd4;
   localparam logic [2:0] HDR_COUNT_HI = 3'd5;

   // Back-length size thresholds.
   localparam logic [31:0] BL_LIMIT1 = 32'd127;
   localparam logic [31:0] BL_LIMIT2 = 32'd16383;
   localparam logic [31:0] BL_LIMIT3 = 32'd2097151;
   localparam logic [31:0] BL_LIMIT4 = 32'd268435455;

   // One result event.
   typedef struct packed {
      event_kind_type      event_kind;
      logic signed [63:0]  int_value;
      logic [31:0]         string_length;
      logic [7:0]          string_byte;
      logic [15:0]         element_number;
      logic                element_last;
   } event_type;

   // Result of one parse step, with its valid flag.
   typedef struct packed {
      logic      valid;
      event_type evt;
   } step_result_type;

endpackage

/* rtl/core/lsp_core.sv */
module lsp_core
   import lsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            pack_start,
   input  logic [7:0]      data_byte,
   output step_result_type result
);

   // Back-length byte count for a given entry size.
   function automatic logic [2:0] backlen_count(input logic [31:0] size);
      logic [2:0] cnt;
      if (size <= BL_LIMIT1) begin
         cnt = 3'd1;
      end else if (size < BL_LIMIT2) begin
         cnt = 3'd2;
      end else if (size < BL_LIMIT3) begin
         cnt = 3'd3;
      end else if (size < BL_LIMIT4) begin
         cnt = 3'd4;
      end else begin
         cnt = 3'd5;
      end
      return cnt;
   endfunction

   phase_type    phase_ff, phase_in, phase_cur;
   logic [2:0]   pos_ff, pos_in, pos_cur;
   logic [15:0]  left_ff, left_in, left_cur;
   logic [15:0]  index_ff, index_in, index_cur;
   enc_kind_type kind_ff, kind_in, kind_cur;
   logic [63:0]  acc_ff, acc_in, acc_cur;
   logic [31:0]  remain_ff, remain_in, remain_cur;
   logic [31:0]  size_ff, size_in, size_cur;
   logic [2:0]   backlen_ff, backlen_in, backlen_cur;

   logic         str_go;
   logic [31:0]  str_len;
   logic [2:0]   str_hdr;
   logic [32:0]  str_sum;
   logic         to_backlen;
   logic [31:0]  remain_dec;
   logic [63:0]  acc_new;

   // A start flag makes the step see the state as just after reset.
   always_comb begin
      if (pack_start) begin
         phase_cur   = PH_HEADER;
         pos_cur     = '0;
         left_cur    = '0;
         index_cur   = '0;
         kind_cur    = K_INT7;
         acc_cur     = '0;
         remain_cur  = '0;
         size_cur    = '0;
         backlen_cur = '0;
      end else begin
         phase_cur   = phase_ff;
         pos_cur     = pos_ff;
         left_cur    = left_ff;
         index_cur   = index_ff;
         kind_cur    = kind_ff;
         acc_cur     = acc_ff;
         remain_cur  = remain_ff;
         size_cur    = size_ff;
         backlen_cur = backlen_ff;
      end
   end

   assign remain_dec = (remain_cur != 32'd0) ? remain_cur - 32'd1 : 32'd0;

   // Payload byte merged into the accumulator.
   always_comb begin
      if (kind_cur == K_INT13 || kind_cur == K_STR12) begin
         acc_new = acc_cur | {56'd0, data_byte};
      end else begin
         acc_new = acc_cur | ({56'd0, data_byte} << {pos_cur, 3'b000});
      end
   end

   // Next state and result event for one byte.
   always_comb begin
      phase_in    = phase_cur;
      pos_in      = pos_cur;
      left_in     = left_cur;
      index_in    = index_cur;
      kind_in     = kind_cur;
      acc_in      = acc_cur;
      remain_in   = remain_cur;
      size_in     = size_cur;
      backlen_in  = backlen_cur;
      str_go      = 1'b0;
      str_len     = '0;
      str_hdr     = '0;
      str_sum     = '0;
      to_backlen  = 1'b0;
      result      = '0;

      case (phase_cur)
         PH_HEADER: begin
            if (pos_cur == HDR_COUNT_LO) begin
               left_in = {8'd0, data_byte};
            end else if (pos_cur == HDR_COUNT_HI) begin
               left_in = {data_byte, left_cur[7:0]};
            end
            if (pos_cur < HDR_COUNT_HI) begin
               pos_in = pos_cur + 3'd1;
            end else begin
               pos_in = '0;
               if (left_in == 16'd0) begin
                  phase_in = PH_DONE;
                  result.valid = 1'b1;
                  result.evt.event_kind = EV_DONE;
               end else begin
                  phase_in = PH_ENC;
               end
            end
         end
         PH_ENC: begin
            if (!data_byte[7]) begin
               size_in = 32'd1;
               to_backlen = 1'b1;
               result.valid = 1'b1;
               result.evt.event_kind = EV_INT;
               result.evt.int_value = {57'd0, data_byte[6:0]};
               result.evt.element_last = 1'b1;
            end else if (data_byte[7:6] == 2'b10) begin
               str_go  = 1'b1;
               str_len = {26'd0, data_byte[5:0]};
               str_hdr = 3'd1;
            end else if (data_byte[7:5] == 3'b110) begin
               kind_in   = K_INT13;
               remain_in = 32'd1;
               pos_in    = '0;
               acc_in    = {51'd0, data_byte[4:0], 8'd0};
               phase_in  = PH_COLLECT;
            end else if (data_byte[7:4] == 4'b1110) begin
               kind_in   = K_STR12;
               remain_in = 32'd1;
               pos_in    = '0;
               acc_in    = {52'd0, data_byte[3:0], 8'd0};
               phase_in  = PH_COLLECT;
            end else begin
               pos_in   = '0;
               acc_in   = '0;
               phase_in = PH_COLLECT;
               case (data_byte)
                  ENC_STR32: begin
                     kind_in   = K_STR32;
                     remain_in = 32'd4;
                  end
                  ENC_INT16: begin
                     kind_in   = K_INT16;
                     remain_in = 32'd2;
                  end
                  ENC_INT24: begin
                     kind_in   = K_INT24;
                     remain_in = 32'd3;
                  end
                  ENC_INT32: begin
                     kind_in   = K_INT32;
                     remain_in = 32'd4;
                  end
                  ENC_INT64: begin
                     kind_in   = K_INT64;
                     remain_in = 32'd8;
                  end
                  default: begin
                     // Reserved encodings lock the parser in the error phase.
                     pos_in   = pos_cur;
                     acc_in   = acc_cur;
                     phase_in = PH_ERROR;
                     result.valid = 1'b1;
                     result.evt.event_kind = EV_ERROR;
                  end
               endcase
            end
         end
         PH_COLLECT: begin
            acc_in    = acc_new;
            pos_in    = pos_cur + 3'd1;
            remain_in = remain_dec;
            if (remain_dec == 32'd0) begin
               case (kind_cur)
                  K_STR12: begin
                     str_go  = 1'b1;
                     str_len = {20'd0, acc_new[11:0]};
                     str_hdr = 3'd2;
                  end
                  K_STR32: begin
                     str_go  = 1'b1;
                     str_len = acc_new[31:0];
                     str_hdr = 3'd5;
                  end
                  default: begin
                     to_backlen = 1'b1;
                     result.valid = 1'b1;
                     result.evt.event_kind = EV_INT;
                     result.evt.element_last = 1'b1;
                     case (kind_cur)
                        K_INT13: begin
                           size_in = 32'd2;
                           result.evt.int_value = {{51{acc_new[12]}}, acc_new[12:0]};
                        end
                        K_INT16: begin
                           size_in = 32'd3;
                           result.evt.int_value = {{48{acc_new[15]}}, acc_new[15:0]};
                        end
                        K_INT24: begin
                           size_in = 32'd4;
                           result.evt.int_value = {{40{acc_new[23]}}, acc_new[23:0]};
                        end
                        K_INT32: begin
                           size_in = 32'd5;
                           result.evt.int_value = {{32{acc_new[31]}}, acc_new[31:0]};
                        end
                        default: begin
                           size_in = 32'd9;
                           result.evt.int_value = acc_new;
                        end
                     endcase
                  end
               endcase
            end
         end
         PH_SDATA: begin
            remain_in = remain_dec;
            result.valid = 1'b1;
            result.evt.event_kind = EV_STR_BYTE;
            result.evt.string_byte = data_byte;
            if (remain_dec == 32'd0) begin
               to_backlen = 1'b1;
               result.evt.element_last = 1'b1;
            end
         end
         PH_BACKLEN: begin
            backlen_in = (backlen_cur != 3'd0) ? backlen_cur - 3'd1 : 3'd0;
            if (backlen_in == 3'd0) begin
               index_in = index_cur + 16'd1;
               left_in  = left_cur - 16'd1;
               if (left_in == 16'd0) begin
                  phase_in = PH_DONE;
                  result.valid = 1'b1;
                  result.evt.event_kind = EV_DONE;
               end else begin
                  phase_in = PH_ENC;
               end
            end
         end
         PH_ERROR: begin
            result.valid = 1'b1;
            result.evt.event_kind = EV_ERROR;
         end
         default: begin
         end
      endcase

      // String length event; the entry size saturates at all ones.
      if (str_go) begin
         str_sum = {30'd0, str_hdr} + {1'b0, str_len};
         size_in = str_sum[32] ? 32'hFFFF_FFFF : str_sum[31:0];
         result.valid = 1'b1;
         result.evt.event_kind = EV_STR_START;
         if (str_len == 32'd0) begin
            to_backlen = 1'b1;
            result.evt.element_last = 1'b1;
         end else begin
            remain_in = str_len;
            phase_in  = PH_SDATA;
            result.evt.string_length = str_len;
         end
      end

      if (to_backlen) begin
         backlen_in = backlen_count(size_in);
         phase_in   = PH_BACKLEN;
      end

      result.evt.element_number = index_in;
   end

   // State registers advance once per consumed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         left_ff    <= '0;
         index_ff   <= '0;
         kind_ff    <= K_INT7;
         acc_ff     <= '0;
         remain_ff  <= '0;
         size_ff    <= '0;
         backlen_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         left_ff    <= left_in;
         index_ff   <= index_in;
         kind_ff    <= kind_in;
         acc_ff     <= acc_in;
         remain_ff  <= remain_in;
         size_ff    <= size_in;
         backlen_ff <= backlen_in;
      end
   end

endmodule

/* rtl/core/listpack_stream_parser.sv */
// Channel  Direction  tdata (low bit up)                          tuser        tlast
// req      in         data_byte[7:0]                              pack_start   -
// rsp      out        int_value[63:0], string_length[31:0],       event_kind   element_last
//                     string_byte[7:0], element_number[15:0]
//
// One byte is taken per cycle while the result is not stalled; a request passes
// an input register, the parser step and the result register before its event
// is presented. The parser state register is the single per-byte loop.
// Reset is synchronous and returns the parser to the header phase.
// A stalled result holds its register while one more request waits in the
// input register; further requests are held off until the result is taken.
module listpack_stream_parser
   import lsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tuser,   // pack_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // int_value, string_length, string_byte, element_number
   output logic [2:0]   rsp_tuser,   // event_kind
   output logic         rsp_tlast    // element_last
);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_start_ff;
   logic            rsp_valid_ff;
   event_type       rsp_ff;
   logic            advance;
   step_result_type result;

   // The held byte is parsed whenever the result register can take its event.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   lsp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .pack_start (in_start_ff),
      .data_byte  (in_byte_ff),
      .result     (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_ff <= result.evt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.element_number, rsp_ff.string_byte,
                        rsp_ff.string_length, rsp_ff.int_value};
   assign rsp_tuser  = rsp_ff.event_kind;
   assign rsp_tlast  = rsp_ff.element_last;

endmodule

/* tb/listpack_event_checker.sv */
module listpack_event_checker
   import lsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tuser,   // pack_start
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [119:0] rsp_tdata,   // int_value, string_length, string_byte, element_number
   input  logic [2:0]   rsp_tuser,   // event_kind
   input  logic         rsp_tlast,   // element_last
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Parser state as the block is expected to hold it.
   phase_type    ps_phase;
   logic [2:0]   ps_pos;
   logic [15:0]  ps_left;
   logic [15:0]  ps_index;
   enc_kind_type ps_kind;
   logic [63:0]  ps_acc;
   logic [31:0]  ps_remain;
   logic [31:0]  ps_size;
   logic [2:0]   ps_backlen;

   // Events predicted from accepted requests, oldest first.
   event_type expected_events[$];

   task automatic restart_parse();
      ps_phase   = PH_HEADER;
      ps_pos     = '0;
      ps_left    = '0;
      ps_index   = '0;
      ps_kind    = K_INT7;
      ps_acc     = '0;
      ps_remain  = '0;
      ps_size    = '0;
      ps_backlen = '0;
   endtask

   function automatic event_type make_event(event_kind_type kind, logic [63:0] ival,
                                            logic [31:0] slen, logic [7:0] sbyte,
                                            logic last);
      event_type ev;
      ev.event_kind     = kind;
      ev.int_value      = ival;
      ev.string_length  = slen;
      ev.string_byte    = sbyte;
      ev.element_number = ps_index;
      ev.element_last   = last;
      return ev;
   endfunction

   // The back-length field grows with the size of the entry it follows.
   task automatic enter_backlen();
      if (ps_size <= BL_LIMIT1) ps_backlen = 3'd1;
      else if (ps_size < BL_LIMIT2) ps_backlen = 3'd2;
      else if (ps_size < BL_LIMIT3) ps_backlen = 3'd3;
      else if (ps_size < BL_LIMIT4) ps_backlen = 3'd4;
      else ps_backlen = 3'd5;
      ps_phase = PH_BACKLEN;
   endtask

   task automatic begin_payload(enc_kind_type kind, logic [31:0] count, logic [63:0] acc);
      ps_kind   = kind;
      ps_remain = count;
      ps_pos    = '0;
      ps_acc    = acc;
      ps_phase  = PH_COLLECT;
   endtask

   // A string length is known; the entry size saturates at 32 bits.
   task automatic open_string(input logic [31:0] len, input logic [31:0] hdr,
                              output event_type ev);
      logic [32:0] sz;
      sz = {1'b0, hdr} + {1'b0, len};
      ps_size = sz[32] ? 32'hFFFF_FFFF : sz[31:0];
      if (len == 32'd0) begin
         enter_backlen();
         ev = make_event(EV_STR_START, 64'd0, 32'd0, 8'd0, 1'b1);
      end else begin
         ps_remain = len;
         ps_phase = PH_SDATA;
         ev = make_event(EV_STR_START, 64'd0, len, 8'd0, 1'b0);
      end
   endtask

   // One parser step for one accepted request.
   task automatic decode_byte(input logic start, input logic [7:0] b,
                              output logic got, output event_type ev);
      logic [63:0] v;
      got = 1'b0;
      ev = '0;
      v = '0;
      if (start) restart_parse();
      case (ps_phase)
         PH_HEADER: begin
            if (ps_pos == HDR_COUNT_LO) ps_left = {8'h00, b};
            else if (ps_pos == HDR_COUNT_HI) ps_left = ps_left | {b, 8'h00};
            if (ps_pos < HDR_COUNT_HI) begin
               ps_pos = ps_pos + 3'd1;
            end else begin
               ps_pos = '0;
               if (ps_left == 16'd0) begin
                  ps_phase = PH_DONE;
                  ev = make_event(EV_DONE, 64'd0, 32'd0, 8'd0, 1'b0);
                  got = 1'b1;
               end else begin
                  ps_phase = PH_ENC;
               end
            end
         end
         PH_ENC: begin
            if (!b[7]) begin
               ps_size = 32'd1;
               enter_backlen();
               ev = make_event(EV_INT, {57'd0, b[6:0]}, 32'd0, 8'd0, 1'b1);
               got = 1'b1;
            end else if (b[7:6] == 2'b10) begin
               open_string({26'd0, b[5:0]}, 32'd1, ev);
               got = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               begin_payload(K_INT13, 32'd1, {51'd0, b[4:0], 8'd0});
            end else if (b[7:4] == 4'b1110) begin
               begin_payload(K_STR12, 32'd1, {52'd0, b[3:0], 8'd0});
            end else begin
               case (b)
                  ENC_STR32: begin_payload(K_STR32, 32'd4, 64'd0);
                  ENC_INT16: begin_payload(K_INT16, 32'd2, 64'd0);
                  ENC_INT24: begin_payload(K_INT24, 32'd3, 64'd0);
                  ENC_INT32: begin_payload(K_INT32, 32'd4, 64'd0);
                  ENC_INT64: begin_payload(K_INT64, 32'd8, 64'd0);
                  default: begin
                     ps_phase = PH_ERROR;
                     ev = make_event(EV_ERROR, 64'd0, 32'd0, 8'd0, 1'b0);
                     got = 1'b1;
                  end
               endcase
            end
         end
         PH_COLLECT: begin
            // The short forms take their low byte; the long forms are little-endian.
            if (ps_kind == K_INT13 || ps_kind == K_STR12) ps_acc = ps_acc | {56'd0, b};
            else ps_acc = ps_acc | ({56'd0, b} << {ps_pos, 3'b000});
            ps_pos = ps_pos + 3'd1;
            if (ps_remain != 32'd0) ps_remain = ps_remain - 32'd1;
            if (ps_remain == 32'd0) begin
               case (ps_kind)
                  K_STR12: open_string({20'd0, ps_acc[11:0]}, 32'd2, ev);
                  K_STR32: open_string(ps_acc[31:0], 32'd5, ev);
                  K_INT13: begin v = {{51{ps_acc[12]}}, ps_acc[12:0]}; ps_size = 32'd2; end
                  K_INT16: begin v = {{48{ps_acc[15]}}, ps_acc[15:0]}; ps_size = 32'd3; end
                  K_INT24: begin v = {{40{ps_acc[23]}}, ps_acc[23:0]}; ps_size = 32'd4; end
                  K_INT32: begin v = {{32{ps_acc[31]}}, ps_acc[31:0]}; ps_size = 32'd5; end
                  default: begin v = ps_acc; ps_size = 32'd9; end
               endcase
               if (ps_kind != K_STR12 && ps_kind != K_STR32) begin
                  enter_backlen();
                  ev = make_event(EV_INT, v, 32'd0, 8'd0, 1'b1);
               end
               got = 1'b1;
            end
         end
         PH_SDATA: begin
            if (ps_remain != 32'd0) ps_remain = ps_remain - 32'd1;
            if (ps_remain == 32'd0) begin
               enter_backlen();
               ev = make_event(EV_STR_BYTE, 64'd0, 32'd0, b, 1'b1);
            end else begin
               ev = make_event(EV_STR_BYTE, 64'd0, 32'd0, b, 1'b0);
            end
            got = 1'b1;
         end
         PH_BACKLEN: begin
            if (ps_backlen != 3'd0) ps_backlen = ps_backlen - 3'd1;
            if (ps_backlen == 3'd0) begin
               ps_index = ps_index + 16'd1;
               ps_left = ps_left - 16'd1;
               if (ps_left == 16'd0) begin
                  ps_phase = PH_DONE;
                  ev = make_event(EV_DONE, 64'd0, 32'd0, 8'd0, 1'b0);
                  got = 1'b1;
               end else begin
                  ps_phase = PH_ENC;
               end
            end
         end
         PH_ERROR: begin
            ev = make_event(EV_ERROR, 64'd0, 32'd0, 8'd0, 1'b0);
            got = 1'b1;
         end
         default: ;
      endcase
   endtask

   // Compare each taken event with the oldest prediction, then predict from the request.
   always @(posedge clock) begin
      event_type seen;
      event_type want;
      event_type ev;
      logic got;
      if (reset) begin
         restart_parse();
         expected_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.event_kind     = event_kind_type'(rsp_tuser);
            seen.int_value      = rsp_tdata[63:0];
            seen.string_length  = rsp_tdata[95:64];
            seen.string_byte    = rsp_tdata[103:96];
            seen.element_number = rsp_tdata[119:104];
            seen.element_last   = rsp_tlast;
            if (expected_events.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: event kind %0d with no request to explain it", $time,
                           rsp_tuser);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (seen.event_kind !== want.event_kind ||
                   seen.int_value !== want.int_value ||
                   seen.string_length !== want.string_length ||
                   seen.string_byte !== want.string_byte ||
                   seen.element_number !== want.element_number ||
                   seen.element_last !== want.element_last) begin
                  if (fail_count < 10) begin
                     $display("%0t: event mismatch", $time);
                     $display("  expected kind %0d int %h len %h byte %h elem %0d last %b",
                              want.event_kind, want.int_value, want.string_length,
                              want.string_byte, want.element_number, want.element_last);
                     $display("  actual   kind %0d int %h len %h byte %h elem %0d last %b",
                              seen.event_kind, seen.int_value, seen.string_length,
                              seen.string_byte, seen.element_number, seen.element_last);
                  end
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tuser, req_tdata, got, ev);
            if (got) expected_events.push_back(ev);
         end
      end
      pending = expected_events.size();
   end

endmodule

/* tb/listpack_stream_parser_test.sv */
module listpack_stream_parser_test;
   import lsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;   // data_byte[7:0]
   logic         req_tuser = 1'b0;   // pack_start
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;          // int_value, string_length, string_byte, element_number
   logic [2:0]   rsp_tuser;          // event_kind
   logic         rsp_tlast;          // element_last

   int   fail_count;
   int   pending;
   int   sent_items = 0;
   int   ignored_items = 0;
   logic calm = 1'b0;
   logic hold_go = 1'b0;

   listpack_stream_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   listpack_event_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog for a hung run.
   initial begin
      #20_000_000;
      $display("listpack_stream_parser_test failed");
      $finish;
   end

   // Receiver: random stalls, a calm stretch, and one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_go) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_go = 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 27);
         end
      end
   end

   // Offer one request; called and returning at a falling edge.
   task automatic send_byte(input logic start, input logic [7:0] b);
      if (!calm) begin
         while ($urandom_range(99) < 27) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_items++;
   endtask

   // Lower valid and let the block drain everything that is predicted.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   function automatic int backlen_bytes(logic [31:0] size);
      if (size <= BL_LIMIT1) return 1;
      if (size < BL_LIMIT2) return 2;
      if (size < BL_LIMIT3) return 3;
      if (size < BL_LIMIT4) return 4;
      return 5;
   endfunction

   // Total size is arbitrary; the element count is little-endian.
   task automatic send_header(input logic start, input logic [15:0] count);
      send_byte(start, 8'($urandom));
      repeat (3) send_byte(1'b0, 8'($urandom));
      send_byte(1'b0, count[7:0]);
      send_byte(1'b0, count[15:8]);
   endtask

   // One well-formed element with its back-length bytes.
   task automatic send_element(input enc_kind_type kind, input logic [31:0] len,
                               input logic [63:0] val);
      int nb;
      int i;
      logic [31:0] size;
      nb = 0;
      size = 0;
      case (kind)
         K_INT7: begin
            send_byte(1'b0, {1'b0, val[6:0]});
            size = 1;
         end
         K_STR6: begin
            send_byte(1'b0, {2'b10, len[5:0]});
            size = 1 + len;
         end
         K_INT13: begin
            send_byte(1'b0, {3'b110, val[12:8]});
            send_byte(1'b0, val[7:0]);
            size = 2;
         end
         K_INT16: begin send_byte(1'b0, ENC_INT16); nb = 2; size = 3; end
         K_INT24: begin send_byte(1'b0, ENC_INT24); nb = 3; size = 4; end
         K_INT32: begin send_byte(1'b0, ENC_INT32); nb = 4; size = 5; end
         K_INT64: begin send_byte(1'b0, ENC_INT64); nb = 8; size = 9; end
         K_STR12: begin
            send_byte(1'b0, {4'b1110, len[11:8]});
            send_byte(1'b0, len[7:0]);
            size = 2 + len;
         end
         default: begin
            send_byte(1'b0, ENC_STR32);
            for (i = 0; i < 4; i++) send_byte(1'b0, len[8*i +: 8]);
            size = 5 + len;
         end
      endcase
      for (i = 0; i < nb; i++) send_byte(1'b0, val[8*i +: 8]);
      if (kind == K_STR6 || kind == K_STR12 || kind == K_STR32)
         for (i = 0; i < len; i++) send_byte(1'b0, 8'($urandom));
      repeat (backlen_bytes(size)) send_byte(1'b0, 8'($urandom));
   endtask

   // Random element; string lengths stay short, some sit at the first size threshold.
   task automatic send_random_element();
      enc_kind_type kind;
      logic [31:0] len;
      kind = enc_kind_type'($urandom_range(8));
      case (kind)
         K_STR6:  len = ($urandom_range(99) < 80) ? $urandom_range(8) : $urandom_range(63, 56);
         K_STR12: len = ($urandom_range(99) < 70) ? $urandom_range(12) : $urandom_range(130, 120);
         K_STR32: len = $urandom_range(6);
         default: len = 0;
      endcase
      send_element(kind, len, {$urandom, $urandom});
   endtask

   initial begin
      int target;
      int pack_no;
      int r;
      int n;
      int k;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Bytes with no start are parsed as a header; an empty pack ends at once,
      // and a byte after the done event is ignored.
      send_header(1'b0, 16'd0);
      send_byte(1'b0, 8'hFF);
      ignored_items++;

      // An empty string, then an invalid encoding whose error repeats.
      send_header(1'b1, 16'd2);
      send_element(K_STR6, 32'd0, 64'd0);
      send_byte(1'b0, 8'hF5);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);

      // A string of the largest length saturates its entry size; cut short by a restart.
      send_header(1'b1, 16'd1);
      send_byte(1'b0, ENC_STR32);
      repeat (4) send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);

      // Random packs: mostly well-formed, some broken or noisy.
      target = sent_items + 1400;
      pack_no = 0;
      while (sent_items - ignored_items < target) begin
         calm = (pack_no >= 20 && pack_no < 35);
         if (pack_no == 4) hold_go = 1'b1;
         r = $urandom_range(99);
         if (r < 75) begin
            n = ($urandom_range(99) < 5) ? 0 : $urandom_range(5, 1);
            send_header(1'b1, 16'(n));
            for (k = 0; k < n; k++) send_random_element();
            if ($urandom_range(1)) begin
               send_byte(1'b0, 8'hFF);
               ignored_items++;
            end
         end else if (r < 88) begin
            send_header(1'b1, 16'($urandom));
            n = $urandom_range(3);
            for (k = 0; k < n; k++) send_random_element();
         end else begin
            send_header(1'b1, 16'($urandom_range(4, 1)));
            n = $urandom_range(10, 1);
            for (k = 0; k < n; k++) send_byte(1'b0, 8'($urandom));
         end
         if (pack_no % 12 == 7) drain();
         pack_no++;
      end
      calm = 1'b0;

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("listpack_stream_parser_test passed");
      end else begin
         $display("listpack_stream_parser_test failed");
      end
      $finish;
   end

endmodule
